// ===== design/psalu_pkg.sv =====
// ----------------------------------------------------------------------------
// psalu_pkg: shared types for the packed integer SIMD ALU
// Opcode codes, control decode and the control struct that steers the
// 64-bit lanes, the cross-lane permute unit and the result merge.
// ----------------------------------------------------------------------------
package psalu_pkg;

  localparam int unsigned NUM_BYTES = 16;

  typedef enum logic [4:0] {
    OP_PXOR    = 5'd0,
    OP_POR     = 5'd1,
    OP_PAND    = 5'd2,
    OP_PANDN   = 5'd3,
    OP_PADDB   = 5'd4,
    OP_PADDW   = 5'd5,
    OP_PADDD   = 5'd6,
    OP_PADDQ   = 5'd7,
    OP_PSUBB   = 5'd8,
    OP_PSUBW   = 5'd9,
    OP_PSUBD   = 5'd10,
    OP_PSUBQ   = 5'd11,
    OP_PSLLW   = 5'd12,
    OP_PSLLD   = 5'd13,
    OP_PSLLQ   = 5'd14,
    OP_PSRLW   = 5'd15,
    OP_PSRLD   = 5'd16,
    OP_PSRLQ   = 5'd17,
    OP_PSRAW   = 5'd18,
    OP_PSRAD   = 5'd19,
    OP_PSLLDQ  = 5'd20,
    OP_PSRLDQ  = 5'd21,
    OP_PSHUFD  = 5'd22,
    OP_PSHUFLW = 5'd23,
    OP_PSHUFHW = 5'd24
  } opcode_t;

  typedef enum logic [1:0] {
    SEL_LANE = 2'd0,
    SEL_PERM = 2'd1,
    SEL_PASS = 2'd2
  } res_sel_t;

  typedef enum logic [2:0] {
    LOP_XOR    = 3'd0,
    LOP_OR     = 3'd1,
    LOP_AND    = 3'd2,
    LOP_ANDN   = 3'd3,
    LOP_ADDSUB = 3'd4,
    LOP_SHIFT  = 3'd5
  } lane_op_t;

  typedef enum logic [1:0] {
    LW_B = 2'd0,
    LW_W = 2'd1,
    LW_D = 2'd2,
    LW_Q = 2'd3
  } lane_width_t;

  typedef enum logic [1:0] {
    SK_LL = 2'd0,
    SK_LR = 2'd1,
    SK_AR = 2'd2
  } shift_kind_t;

  typedef enum logic [2:0] {
    PM_BSL    = 3'd0,
    PM_BSR    = 3'd1,
    PM_SHUFD  = 3'd2,
    PM_SHUFLW = 3'd3,
    PM_SHUFHW = 3'd4
  } perm_op_t;

  typedef struct packed {
    res_sel_t    sel;
    lane_op_t    lop;
    lane_width_t width;
    logic        sub;
    shift_kind_t kind;
    perm_op_t    pop;
  } op_ctrl_t;

  function automatic op_ctrl_t decode_op(input logic [4:0] op);
    op_ctrl_t c;
    c.sel   = SEL_LANE;
    c.lop   = LOP_XOR;
    c.width = LW_B;
    c.sub   = 1'b0;
    c.kind  = SK_LL;
    c.pop   = PM_BSL;
    case (op)
      OP_PXOR:    c.lop = LOP_XOR;
      OP_POR:     c.lop = LOP_OR;
      OP_PAND:    c.lop = LOP_AND;
      OP_PANDN:   c.lop = LOP_ANDN;
      OP_PADDB:   begin c.lop = LOP_ADDSUB; c.width = LW_B; end
      OP_PADDW:   begin c.lop = LOP_ADDSUB; c.width = LW_W; end
      OP_PADDD:   begin c.lop = LOP_ADDSUB; c.width = LW_D; end
      OP_PADDQ:   begin c.lop = LOP_ADDSUB; c.width = LW_Q; end
      OP_PSUBB:   begin c.lop = LOP_ADDSUB; c.width = LW_B; c.sub = 1'b1; end
      OP_PSUBW:   begin c.lop = LOP_ADDSUB; c.width = LW_W; c.sub = 1'b1; end
      OP_PSUBD:   begin c.lop = LOP_ADDSUB; c.width = LW_D; c.sub = 1'b1; end
      OP_PSUBQ:   begin c.lop = LOP_ADDSUB; c.width = LW_Q; c.sub = 1'b1; end
      OP_PSLLW:   begin c.lop = LOP_SHIFT; c.width = LW_W; c.kind = SK_LL; end
      OP_PSLLD:   begin c.lop = LOP_SHIFT; c.width = LW_D; c.kind = SK_LL; end
      OP_PSLLQ:   begin c.lop = LOP_SHIFT; c.width = LW_Q; c.kind = SK_LL; end
      OP_PSRLW:   begin c.lop = LOP_SHIFT; c.width = LW_W; c.kind = SK_LR; end
      OP_PSRLD:   begin c.lop = LOP_SHIFT; c.width = LW_D; c.kind = SK_LR; end
      OP_PSRLQ:   begin c.lop = LOP_SHIFT; c.width = LW_Q; c.kind = SK_LR; end
      OP_PSRAW:   begin c.lop = LOP_SHIFT; c.width = LW_W; c.kind = SK_AR; end
      OP_PSRAD:   begin c.lop = LOP_SHIFT; c.width = LW_D; c.kind = SK_AR; end
      OP_PSLLDQ:  begin c.sel = SEL_PERM; c.pop = PM_BSL; end
      OP_PSRLDQ:  begin c.sel = SEL_PERM; c.pop = PM_BSR; end
      OP_PSHUFD:  begin c.sel = SEL_PERM; c.pop = PM_SHUFD; end
      OP_PSHUFLW: begin c.sel = SEL_PERM; c.pop = PM_SHUFLW; end
      OP_PSHUFHW: begin c.sel = SEL_PERM; c.pop = PM_SHUFHW; end
      default:    c.sel = SEL_PASS;
    endcase
    return c;
  endfunction

endpackage

// ===== design/packed_integer_simd_alu_unit.sv =====
// ----------------------------------------------------------------------------
// packed_integer_simd_alu_unit: 128-bit packed integer ALU
// Two 64-bit lanes handle logic, add/subtract and element shifts; a
// cross-lane unit handles byte shifts and shuffles; a merge stage picks
// the result and registers it.
//
//   channel   handshake              payload
//   input     in_valid / in_ready    opcode, dst_low, dst_high, src_low,
//                                    src_high, imm_byte, count_from_imm
//   output    out_valid / out_ready  result_low, result_high
//
// One item per cycle while the output is not stalled; each result is
// registered in the single output register after the lanes.
// A one-item skid register keeps in_ready high for one further item while
// the output is stalled; in_ready drops only once the skid register is full.
// rst (synchronous) empties the output and skid registers.
// ----------------------------------------------------------------------------
module packed_integer_simd_alu_unit
  import psalu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  opcode,
  input  logic [63:0] dst_low,
  input  logic [63:0] dst_high,
  input  logic [63:0] src_low,
  input  logic [63:0] src_high,
  input  logic [7:0]  imm_byte,
  input  logic        count_from_imm,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] result_low,
  output logic [63:0] result_high
);

  op_ctrl_t     ctrl;
  logic [63:0]  count;
  logic [63:0]  lane_lo_res;
  logic [63:0]  lane_hi_res;
  logic [127:0] perm_res;
  logic         accept;

  assign ctrl   = decode_op(opcode);
  assign count  = count_from_imm ? {56'b0, imm_byte} : src_low;
  assign accept = in_valid && in_ready;

  psalu_lane u_lane_lo (
    .ctrl  (ctrl),
    .dst   (dst_low),
    .src   (src_low),
    .count (count),
    .res   (lane_lo_res)
  );

  psalu_lane u_lane_hi (
    .ctrl  (ctrl),
    .dst   (dst_high),
    .src   (src_high),
    .count (count),
    .res   (lane_hi_res)
  );

  psalu_perm u_perm (
    .ctrl (ctrl),
    .dst  ({dst_high, dst_low}),
    .src  ({src_high, src_low}),
    .imm  (imm_byte),
    .res  (perm_res)
  );

  psalu_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .sel         (ctrl.sel),
    .lane_res    ({lane_hi_res, lane_lo_res}),
    .perm_res    (perm_res),
    .dst         ({dst_high, dst_low}),
    .ready       (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_low  (result_low),
    .result_high (result_high)
  );

endmodule

// ===== design/psalu_lane.sv =====
// ----------------------------------------------------------------------------
// psalu_lane: one 64-bit lane of the packed ALU
// Bitwise logic, segmented add/subtract and per-element shifts on one
// 64-bit half of the operands.
// ----------------------------------------------------------------------------
module psalu_lane
  import psalu_pkg::*;
(
  input  op_ctrl_t    ctrl,
  input  logic [63:0] dst,
  input  logic [63:0] src,
  input  logic [63:0] count,
  output logic [63:0] res
);

  logic [63:0] addsub_res;
  logic [63:0] word_res;
  logic [63:0] dword_res;
  logic [63:0] qword_res;
  logic [63:0] shift_res;
  logic        big16;
  logic        big32;
  logic        big64;

  // Byte-slice adder; break the carry at each element boundary.
  always_comb begin
    logic [63:0] b_opnd;
    logic        carry;
    logic        start;
    logic [8:0]  bsum;
    b_opnd = ctrl.sub ? ~src : src;
    carry  = ctrl.sub;
    start  = 1'b1;
    bsum   = '0;
    addsub_res = '0;
    for (int k = 0; k < 8; k++) begin
      case (ctrl.width)
        LW_B:    start = 1'b1;
        LW_W:    start = (k[0] == 1'b0);
        LW_D:    start = (k[1:0] == 2'b00);
        LW_Q:    start = (k == 0);
        default: start = 1'b1;
      endcase
      if (start) begin
        carry = ctrl.sub;
      end
      bsum = {1'b0, dst[8*k +: 8]} + {1'b0, b_opnd[8*k +: 8]} + {8'b0, carry};
      addsub_res[8*k +: 8] = bsum[7:0];
      carry = bsum[8];
    end
  end

  // Count is not masked: anything past the element width saturates.
  assign big16 = |count[63:4];
  assign big32 = |count[63:5];
  assign big64 = |count[63:6];

  for (genvar i = 0; i < 4; i++) begin : g_word
    logic [15:0] v;
    assign v = dst[16*i +: 16];
    always_comb begin
      case (ctrl.kind)
        SK_LL:   word_res[16*i +: 16] = big16 ? 16'b0 : (v << count[3:0]);
        SK_LR:   word_res[16*i +: 16] = big16 ? 16'b0 : (v >> count[3:0]);
        SK_AR:   word_res[16*i +: 16] = $signed(v) >>> (big16 ? 4'd15 : count[3:0]);
        default: word_res[16*i +: 16] = 16'b0;
      endcase
    end
  end

  for (genvar i = 0; i < 2; i++) begin : g_dword
    logic [31:0] v;
    assign v = dst[32*i +: 32];
    always_comb begin
      case (ctrl.kind)
        SK_LL:   dword_res[32*i +: 32] = big32 ? 32'b0 : (v << count[4:0]);
        SK_LR:   dword_res[32*i +: 32] = big32 ? 32'b0 : (v >> count[4:0]);
        SK_AR:   dword_res[32*i +: 32] = $signed(v) >>> (big32 ? 5'd31 : count[4:0]);
        default: dword_res[32*i +: 32] = 32'b0;
      endcase
    end
  end

  always_comb begin
    case (ctrl.kind)
      SK_LL:   qword_res = big64 ? 64'b0 : (dst << count[5:0]);
      SK_LR:   qword_res = big64 ? 64'b0 : (dst >> count[5:0]);
      SK_AR:   qword_res = $signed(dst) >>> (big64 ? 6'd63 : count[5:0]);
      default: qword_res = 64'b0;
    endcase
  end

  always_comb begin
    case (ctrl.width)
      LW_W:    shift_res = word_res;
      LW_D:    shift_res = dword_res;
      LW_Q:    shift_res = qword_res;
      default: shift_res = word_res;
    endcase
  end

  always_comb begin
    case (ctrl.lop)
      LOP_XOR:    res = dst ^ src;
      LOP_OR:     res = dst | src;
      LOP_AND:    res = dst & src;
      LOP_ANDN:   res = ~dst & src;
      LOP_ADDSUB: res = addsub_res;
      LOP_SHIFT:  res = shift_res;
      default:    res = dst;
    endcase
  end

endmodule

// ===== design/psalu_perm.sv =====
// ----------------------------------------------------------------------------
// psalu_perm: cross-lane permute unit
// Whole-register byte shifts of the destination and immediate-driven
// dword/word shuffles of the source.
// ----------------------------------------------------------------------------
module psalu_perm
  import psalu_pkg::*;
(
  input  op_ctrl_t     ctrl,
  input  logic [127:0] dst,
  input  logic [127:0] src,
  input  logic [7:0]   imm,
  output logic [127:0] res
);

  logic         big;
  logic [6:0]   bit_shamt;
  logic [127:0] bsl_res;
  logic [127:0] bsr_res;
  logic [127:0] shufd_res;
  logic [127:0] shuflw_res;
  logic [127:0] shufhw_res;
  logic [63:0]  src_lo;
  logic [63:0]  src_hi;

  assign big       = (imm >= 8'(NUM_BYTES));
  assign bit_shamt = {imm[3:0], 3'b000};
  assign bsl_res   = big ? 128'b0 : (dst << bit_shamt);
  assign bsr_res   = big ? 128'b0 : (dst >> bit_shamt);

  assign src_lo = src[63:0];
  assign src_hi = src[127:64];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      shufd_res[32*i +: 32] = src[{imm[2*i +: 2], 5'b00000} +: 32];
    end
  end

  // The half that is not shuffled passes straight from the source.
  always_comb begin
    shuflw_res[127:64] = src_hi;
    shufhw_res[63:0]   = src_lo;
    for (int i = 0; i < 4; i++) begin
      shuflw_res[16*i +: 16]      = src_lo[{imm[2*i +: 2], 4'b0000} +: 16];
      shufhw_res[64 + 16*i +: 16] = src_hi[{imm[2*i +: 2], 4'b0000} +: 16];
    end
  end

  always_comb begin
    case (ctrl.pop)
      PM_BSL:    res = bsl_res;
      PM_BSR:    res = bsr_res;
      PM_SHUFD:  res = shufd_res;
      PM_SHUFLW: res = shuflw_res;
      PM_SHUFHW: res = shufhw_res;
      default:   res = bsl_res;
    endcase
  end

endmodule

// ===== design/psalu_merge.sv =====
// ----------------------------------------------------------------------------
// psalu_merge: result merge and output buffering
// Picks the lane, permute or pass-through result and holds it in an
// output register backed by a one-item skid register.
// ----------------------------------------------------------------------------
module psalu_merge
  import psalu_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         accept,
  input  res_sel_t     sel,
  input  logic [127:0] lane_res,
  input  logic [127:0] perm_res,
  input  logic [127:0] dst,
  output logic         ready,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [63:0]  result_low,
  output logic [63:0]  result_high
);

  logic [127:0] merged;
  logic [127:0] out_data;
  logic [127:0] skid_data;
  logic         skid_valid;
  logic         out_load;

  always_comb begin
    case (sel)
      SEL_LANE: merged = lane_res;
      SEL_PERM: merged = perm_res;
      SEL_PASS: merged = dst;
      default:  merged = dst;
    endcase
  end

  assign out_load = !out_valid || out_ready;
  assign ready    = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_load) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Park a new item in the skid register while the output is stalled.
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= merged;
      end
    end else if (accept) begin
      skid_data <= merged;
    end
  end

  assign result_low  = out_data[63:0];
  assign result_high = out_data[127:64];

  ap_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  ap_skid_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !out_ready) |=> skid_valid)
    else $error("skid item dropped during output stall");

  ap_stall_to_skid: assert property (@(posedge clk) disable iff (rst)
    (accept && out_valid && !out_ready) |=> skid_valid)
    else $error("item accepted during stall not parked");

  ap_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_ready) |=> (out_valid && !skid_valid))
    else $error("skid item not moved to output");

endmodule

// ===== dv/packed_integer_simd_alu_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_integer_simd_alu_unit_tb: self-checking bench for the 128-bit ALU
// Drives a short table of corner cases (every opcode, unmasked shift counts,
// byte shifts past the register, pass-through of an unused opcode), then
// random items in bursts while the result side stalls on its own pattern,
// including one long hold-off. Each result is compared against its table
// entry or a local model of the lane, shift and shuffle datapath.
// ----------------------------------------------------------------------------
module packed_integer_simd_alu_unit_tb;
  import psalu_pkg::*;

  localparam int          NUM_DIRECTED     = 26;
  localparam int          NUM_RANDOM       = 1850;
  localparam int          HOLD_AFTER_ITEMS = 500;
  localparam int          HOLD_CYCLES      = 300;
  localparam int          WATCHDOG_LIMIT   = 4000;
  localparam logic [4:0]  OP_UNUSED_FIRST  = 5'd25;
  localparam logic [4:0]  OP_UNUSED_LAST   = 5'd31;

  localparam logic [63:0] ONES = {64{1'b1}};
  localparam logic [63:0] WA   = 64'hDEAD_BEEF_0123_4567;
  localparam logic [63:0] WB   = 64'h89AB_CDEF_FEDC_BA98;
  localparam logic [63:0] WC   = 64'h0F1E_2D3C_4B5A_6978;
  localparam logic [63:0] WD   = 64'hF0E1_D2C3_B4A5_9687;
  localparam logic [63:0] B01  = 64'h0101_0101_0101_0101;

  typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_EVERY_THIRD} ready_mode_t;

  typedef struct {
    logic [4:0]   op;
    logic [127:0] dst;
    logic [127:0] src;
    logic [7:0]   imm;
    logic         cnt_imm;
    logic         is_typed;
    logic [127:0] typed_result;
  } alu_item_t;

  logic        clk;
  logic        rst            = 1'b1;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [4:0]  opcode         = '0;
  logic [63:0] dst_low        = '0;
  logic [63:0] dst_high       = '0;
  logic [63:0] src_low        = '0;
  logic [63:0] src_high       = '0;
  logic [7:0]  imm_byte       = '0;
  logic        count_from_imm = 1'b0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [63:0] result_low;
  logic [63:0] result_high;

  logic [127:0] pending_results[$];
  int           error_count     = 0;
  int           items_sent      = 0;
  int           results_checked = 0;
  int           in_stall_cycles = 0;
  int           idle_cycles     = 0;
  int           burst_left      = 0;
  logic         held_off        = 1'b0;
  logic [31:0]  ops_seen        = '0;

  alu_item_t directed_rows [NUM_DIRECTED] = '{
    '{OP_PXOR,    {WA, WB}, {WA, WB}, 8'h00, 1'b1, 1'b1, 128'd0},
    '{OP_POR,     128'd0, {ONES, ONES}, 8'h00, 1'b1, 1'b1, {ONES, ONES}},
    '{OP_PAND,    {ONES, ONES}, {WA, WB}, 8'h00, 1'b1, 1'b1, {WA, WB}},
    '{OP_PANDN,   {ONES, ONES}, {ONES, ONES}, 8'h00, 1'b1, 1'b1, 128'd0},
    '{OP_PADDB,   {ONES, ONES}, {B01, B01}, 8'h00, 1'b1, 1'b1, 128'd0},
    '{OP_PADDW,   {WA, WB}, {WC, WD}, 8'h00, 1'b1, 1'b0, 128'd0},
    '{OP_PADDD,   {WA, WB}, {WD, WC}, 8'h00, 1'b1, 1'b0, 128'd0},
    '{OP_PADDQ,   {2{64'h7FFF_FFFF_FFFF_FFFF}}, {2{64'd1}}, 8'h00, 1'b1, 1'b1,
                  {2{64'h8000_0000_0000_0000}}},
    '{OP_PSUBB,   128'd0, {B01, B01}, 8'h00, 1'b1, 1'b1, {ONES, ONES}},
    '{OP_PSUBW,   {WC, WD}, {WA, WB}, 8'h00, 1'b1, 1'b0, 128'd0},
    '{OP_PSUBD,   {WB, WA}, {WC, WD}, 8'h00, 1'b1, 1'b0, 128'd0},
    '{OP_PSUBQ,   128'd0, {ONES, ONES}, 8'h00, 1'b1, 1'b1, {2{64'd1}}},
    // lane shifts with counts near, at or past the lane width
    '{OP_PSLLW,   {ONES, ONES}, {WA, WB}, 8'd16, 1'b1, 1'b1, 128'd0},
    '{OP_PSLLD,   {WA, WB}, {WC, WD}, 8'd31, 1'b1, 1'b0, 128'd0},
    '{OP_PSLLQ,   {ONES, ONES}, {WA, 64'd64}, 8'h00, 1'b0, 1'b1, 128'd0},
    '{OP_PSRLW,   {WA, WB}, {WC, WD}, 8'd15, 1'b1, 1'b0, 128'd0},
    '{OP_PSRLD,   {ONES, ONES}, {WA, 64'h8000_0000_0000_0000}, 8'h00, 1'b0, 1'b1,
                  128'd0},
    '{OP_PSRLQ,   {WA, WB}, {WC, WD}, 8'd63, 1'b1, 1'b0, 128'd0},
    '{OP_PSRAW,   {2{64'h8000_7FFF_8000_7FFF}}, {WC, WD}, 8'd255, 1'b1, 1'b1,
                  {2{64'hFFFF_0000_FFFF_0000}}},
    '{OP_PSRAD,   {2{64'h8000_0001_7FFF_FFFF}}, {ONES, ONES}, 8'h00, 1'b0, 1'b1,
                  {2{64'hFFFF_FFFF_0000_0000}}},
    // byte shifts: whole register gone, and one byte left
    '{OP_PSLLDQ,  {WA, WB}, {WC, WD}, 8'd16, 1'b1, 1'b1, 128'd0},
    '{OP_PSRLDQ,  {WA, WB}, {WC, WD}, 8'd15, 1'b1, 1'b0, 128'd0},
    '{OP_PSHUFD,  {WA, WB}, {WC, WD}, 8'h1B, 1'b1, 1'b0, 128'd0},
    '{OP_PSHUFLW, {WA, WB}, {WC, WD}, 8'hE4, 1'b1, 1'b1, {WC, WD}},
    '{OP_PSHUFHW, {WA, WB}, {WC, WD}, 8'h1B, 1'b1, 1'b0, 128'd0},
    // opcode outside the table leaves the destination as it is
    '{OP_UNUSED_FIRST, {WA, WB}, {WC, WD}, 8'h5A, 1'b0, 1'b1, {WA, WB}}
  };

  packed_integer_simd_alu_unit dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .dst_low        (dst_low),
    .dst_high       (dst_high),
    .src_low        (src_low),
    .src_high       (src_high),
    .imm_byte       (imm_byte),
    .count_from_imm (count_from_imm),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_low     (result_low),
    .result_high    (result_high)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic logic [127:0] alu_predict(input logic [4:0] op, input logic [127:0] d,
                                               input logic [127:0] s, input logic [7:0] imm,
                                               input logic cnt_imm);
    logic [127:0] r, lane_m, v, z;
    logic [63:0]  cnt;
    int unsigned  w, c;
    int           off, i, sel;
    r   = d;
    cnt = cnt_imm ? {56'd0, imm} : s[63:0];
    case (op)
      OP_PXOR:  r = d ^ s;
      OP_POR:   r = d | s;
      OP_PAND:  r = d & s;
      OP_PANDN: r = ~d & s;
      OP_PADDB, OP_PADDW, OP_PADDD, OP_PADDQ,
      OP_PSUBB, OP_PSUBW, OP_PSUBD, OP_PSUBQ: begin
        // low two opcode bits pick byte/word/dword/qword for both add and sub
        w      = 8 << op[1:0];
        lane_m = (128'd1 << w) - 128'd1;
        r      = '0;
        for (off = 0; off < 128; off += w) begin
          v = (d >> off) & lane_m;
          z = (s >> off) & lane_m;
          z = ((op >= OP_PSUBB) ? v - z : v + z) & lane_m;
          r |= z << off;
        end
      end
      OP_PSLLW, OP_PSLLD, OP_PSLLQ, OP_PSRLW, OP_PSRLD,
      OP_PSRLQ, OP_PSRAW, OP_PSRAD: begin
        case (op)
          OP_PSLLW, OP_PSRLW, OP_PSRAW: w = 16;
          OP_PSLLD, OP_PSRLD, OP_PSRAD: w = 32;
          default:                      w = 64;
        endcase
        lane_m = (128'd1 << w) - 128'd1;
        r      = '0;
        for (off = 0; off < 128; off += w) begin
          v = (d >> off) & lane_m;
          if (op == OP_PSRAW || op == OP_PSRAD) begin
            // clamp to width - 1: the sign fills the whole lane
            c = (cnt >= w) ? w - 1 : int'(cnt);
            z = v >> c;
            if (v[w-1] && c > 0) z |= lane_m & ~(lane_m >> c);
          end else if (cnt >= w) begin
            z = '0;
          end else if (op <= OP_PSLLQ) begin
            z = (v << cnt) & lane_m;
          end else begin
            z = v >> cnt;
          end
          r |= z << off;
        end
      end
      OP_PSLLDQ, OP_PSRLDQ: begin
        if (imm >= 8'd16) r = '0;
        else if (op == OP_PSLLDQ) r = d << {imm, 3'b000};
        else r = d >> {imm, 3'b000};
      end
      OP_PSHUFD: begin
        for (i = 0; i < 4; i++) begin
          sel = (imm >> (2 * i)) & 3;
          r[32*i +: 32] = s[32*sel +: 32];
        end
      end
      OP_PSHUFLW, OP_PSHUFHW: begin
        // untouched half passes from the source
        r   = s;
        off = (op == OP_PSHUFHW) ? 64 : 0;
        for (i = 0; i < 4; i++) begin
          sel = (imm >> (2 * i)) & 3;
          r[off + 16*i +: 16] = s[off + 16*sel +: 16];
        end
      end
      default: r = d;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(7, 0))
      0:       return '0;
      1:       return '1;
      2:       return 64'h8000_8000_8000_8000 | 64'($urandom_range(255, 0));
      3:       return 64'd1 << $urandom_range(63, 0);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic alu_item_t random_item();
    alu_item_t it;
    if ($urandom_range(99, 0) < 6)
      it.op = 5'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
    else
      it.op = 5'($urandom_range(OP_PSHUFHW, OP_PXOR));
    it.dst          = {rand_word(), rand_word()};
    it.src          = {rand_word(), rand_word()};
    it.imm          = 8'($urandom_range(255, 0));
    it.cnt_imm      = 1'($urandom_range(1, 0));
    it.is_typed     = 1'b0;
    it.typed_result = '0;
    // favor counts around the lane widths so both sides of the limit get hit
    if (it.op >= OP_PSLLW && it.op <= OP_PSRAD && $urandom_range(9, 0) < 7) begin
      if (it.cnt_imm) it.imm = 8'($urandom_range(66, 0));
      else it.src[63:0] = 64'($urandom_range(66, 0));
    end
    if ((it.op == OP_PSLLDQ || it.op == OP_PSRLDQ) && $urandom_range(3, 0) != 0)
      it.imm = 8'($urandom_range(17, 0));
    return it;
  endfunction

  task automatic offer_item(input alu_item_t it);
    opcode         <= it.op;
    dst_low        <= it.dst[63:0];
    dst_high       <= it.dst[127:64];
    src_low        <= it.src[63:0];
    src_high       <= it.src[127:64];
    imm_byte       <= it.imm;
    count_from_imm <= it.cnt_imm;
    in_valid       <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(it.is_typed ? it.typed_result :
                              alu_predict(it.op, it.dst, it.src, it.imm, it.cnt_imm));
    items_sent++;
    ops_seen[it.op] = 1'b1;
  endtask

  // hold valid through a burst, drop it for a short gap between bursts
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(6, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(24, 0);
    end
  endtask

  initial begin : sender
    while (rst) @(posedge clk);
    foreach (directed_rows[i]) begin
      offer_item(directed_rows[i]);
      pace_sender();
    end
    repeat (NUM_RANDOM) begin
      offer_item(random_item());
      pace_sender();
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Ran %0d items over %0d distinct opcodes; %0d results checked.",
             items_sent, $countones(ops_seen), results_checked);
    $display("Input side was back-pressured for %0d cycles.", in_stall_cycles);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : receiver
    ready_mode_t mode;
    int          seg_len, k;
    while (rst) @(posedge clk);
    forever begin
      if (!held_off && items_sent >= HOLD_AFTER_ITEMS) begin
        // long hold-off: let the unit fill and stall its input
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held_off = 1'b1;
      end
      mode    = ready_mode_t'($urandom_range(3, 0));
      seg_len = $urandom_range(40, 1);
      for (k = 0; k < seg_len; k++) begin
        case (mode)
          RDY_ALWAYS:      out_ready <= 1'b1;
          RDY_COIN:        out_ready <= 1'($urandom_range(1, 0));
          RDY_SPARSE:      out_ready <= ($urandom_range(3, 0) == 0);
          RDY_EVERY_THIRD: out_ready <= (k % 3 == 0);
          default:         out_ready <= 1'b1;
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    logic [127:0] want;
    if (!rst) begin
      if (in_valid && !in_ready) in_stall_cycles++;
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result with no item pending: result_high %h result_low %h",
                 result_high, result_low);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (result_low !== want[63:0]) begin
            $error("result_low mismatch: expected %h, actual %h", want[63:0], result_low);
            error_count++;
          end
          if (result_high !== want[127:64]) begin
            $error("result_high mismatch: expected %h, actual %h", want[127:64], result_high);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
               idle_cycles, pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
